// ===== rtl/jtme_pkg.sv =====
// ============================================================================
// jtme_pkg
// Shared types for the JSON topic/message escaper: the byte class and the
// command word that the front end hands to the back end through the queue.
// ============================================================================
package jtme_pkg;

    // How the single data byte of an input word is rendered.
    typedef enum logic [1:0] {
        K_NONE  = 2'd0,  // no data byte
        K_PLAIN = 2'd1,  // byte goes out as it is
        K_ESC2  = 2'd2,  // backslash followed by the byte held in data
        K_ESC6  = 2'd3   // backslash u 0 0 and two hex digits of data
    } t_kind;

    // One command: the framing texts and the byte that one input word causes.
    typedef struct packed {
        logic       head;   // opening text before everything else
        logic       mpre;   // middle text before the byte (implicit topic close)
        t_kind      kind;   // rendering of the data byte
        logic [7:0] data;   // raw byte, or the escape letter for K_ESC2
        logic       mpost;  // middle text after the byte (topic close)
        logic       tail;   // closing text after the byte (message close)
    } t_cmd;

endpackage

// ===== rtl/json_topic_message_escaper.sv =====
// ============================================================================
// json_topic_message_escaper
// Frames a topic and a content section as { "TOPIC" : "<topic>",
// "CONTENT" : <content> }, escaping the topic as a JSON string.
// ============================================================================
// Usage:
// The input channel (i_valid / o_ready) takes one word per cycle: a byte, its
// section, a has-byte flag and a section-end flag. The output channel
// (o_valid / i_ready) delivers the framed text one byte per word, flagging
// the last byte caused by each input word and the closing brace.
// The front end classifies each input word into a command and the back end
// expands it; a queue of QUEUE_DEPTH commands sits between them, so input
// keeps flowing while the output register holds a byte the receiver has not
// taken.
// Each accepted word reaches the output via the queue and the output register.
// Throughput is one output byte per cycle, set by the back-end sequencer and
// its single output register: a word that maps to one byte gives one byte,
// an escape gives two or six, and the framing texts add 13, 15 or 2 bytes.
// When the receiver stalls, the output byte holds and the queue fills; once
// it is full o_ready drops until the back end pops a command.
// Reset clears the framing state (no message open), the queue and the
// output valid flag; it is synchronous.
// ============================================================================
module json_topic_message_escaper #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_section,
    input  logic       i_has_byte,
    input  logic       i_section_end,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run,
    output logic       o_end_of_message
);
    import jtme_pkg::*;

    logic w_room;
    logic w_push;
    logic w_pop;
    logic w_q_valid;
    t_cmd w_push_cmd;
    t_cmd w_head_cmd;

    // Front end: tracks whether a message is open and whether the topic has
    // been closed, and turns each word into a command. Words that cause no
    // output (an empty item inside an open message) are dropped here.
    jtme_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_room        (w_room),
        .i_data_byte   (i_data_byte),
        .i_section     (i_section),
        .i_has_byte    (i_has_byte),
        .i_section_end (i_section_end),
        .o_push        (w_push),
        .o_cmd         (w_push_cmd)
    );

    // Decoupling queue; the input is ready whenever it has a free slot.
    jtme_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_room  (w_room),
        .o_valid (w_q_valid),
        .o_cmd   (w_head_cmd)
    );

    // Back end: walks the head command phase by phase and pops it with its
    // last byte; the next command starts in the following cycle if the receiver is ready.
    jtme_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (w_q_valid),
        .i_q_cmd          (w_head_cmd),
        .o_pop            (w_pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_out_byte       (o_out_byte),
        .o_last_of_run    (o_last_of_run),
        .o_end_of_message (o_end_of_message)
    );

    assign o_ready = w_room;

    // The closing brace always ends the run of its input word.
    a_eom_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_end_of_message) |-> o_last_of_run)
        else $error("end of message without last of run");

    // The end-of-message byte is the closing brace.
    a_eom_brace: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_end_of_message) |-> (o_out_byte == 8'h7D))
        else $error("end of message on a byte other than the brace");

    // A command is pushed only into a queue with room.
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> w_room)
        else $error("push into a full queue");

    // Pops only happen while the queue holds a command.
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("pop from an empty queue");

    // Reset leaves no output word pending.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

// ===== rtl/jtme_front.sv =====
// ============================================================================
// jtme_front
// Accepts input words, tracks the message framing state and classifies each
// word into one command for the queue.
// ============================================================================
module jtme_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_room,
    input  logic [7:0]      i_data_byte,
    input  logic            i_section,
    input  logic            i_has_byte,
    input  logic            i_section_end,
    output logic            o_push,
    output jtme_pkg::t_cmd  o_cmd
);
    import jtme_pkg::*;

    logic r_open;
    logic r_in_content;
    logic n_open;
    logic n_in_content;
    logic w_content;
    logic w_accept;
    logic w_empty;
    t_cmd w_cmd;

    // Escape class of a topic byte; the data field carries the escape letter
    // for two-byte escapes and the byte itself otherwise.
    function automatic t_cmd fn_escape(input logic [7:0] c);
        t_cmd r;
        r       = '0;
        r.kind  = K_ESC2;
        r.data  = c;
        unique case (c)
            8'h22:   r.data = 8'h22;
            8'h5C:   r.data = 8'h5C;
            8'h08:   r.data = 8'h62;
            8'h0C:   r.data = 8'h66;
            8'h0A:   r.data = 8'h6E;
            8'h0D:   r.data = 8'h72;
            8'h09:   r.data = 8'h74;
            default: r.kind = (c < 8'h20) ? K_ESC6 : K_PLAIN;
        endcase
        return r;
    endfunction

    assign w_content = i_section | r_in_content;
    assign w_accept  = i_valid & i_room;

    always_comb begin
        w_cmd      = '0;
        w_cmd.data = i_data_byte;
        if (!w_content) begin
            if (i_has_byte) begin
                w_cmd = fn_escape(i_data_byte);
            end
            w_cmd.mpost = i_section_end;
        end else begin
            w_cmd.mpre = ~r_in_content;
            w_cmd.kind = i_has_byte ? K_PLAIN : K_NONE;
            w_cmd.tail = i_section_end;
        end
        w_cmd.head = ~r_open;
    end

    assign w_empty = ~w_cmd.head & ~w_cmd.mpre & ~w_cmd.mpost & ~w_cmd.tail
                   & (w_cmd.kind == K_NONE);

    assign n_open       = ~(w_content & i_section_end);
    assign n_in_content = w_content ? ~i_section_end : i_section_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open       <= 1'b0;
            r_in_content <= 1'b0;
        end else if (w_accept) begin
            r_open       <= n_open;
            r_in_content <= n_in_content;
        end
    end

    assign o_push = w_accept & ~w_empty;
    assign o_cmd  = w_cmd;

endmodule

// ===== rtl/jtme_queue.sv =====
// ============================================================================
// jtme_queue
// Short command queue between the front end and the back end.
// ============================================================================
module jtme_queue #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  jtme_pkg::t_cmd  i_cmd,
    input  logic            i_pop,
    output logic            o_room,
    output logic            o_valid,
    output jtme_pkg::t_cmd  o_cmd
);
    import jtme_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_cnt;
    logic          w_push;
    logic          w_pop;

    assign o_room  = (r_cnt != FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign w_push  = i_push & o_room;
    assign w_pop   = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/jtme_back.sv =====
// ============================================================================
// jtme_back
// Expands the command at the head of the queue into output bytes, one per
// cycle while the receiver is ready, and holds them in the output register.
// ============================================================================
module jtme_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  jtme_pkg::t_cmd  i_q_cmd,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_last_of_run,
    output logic            o_end_of_message
);
    import jtme_pkg::*;

    typedef enum logic [2:0] {
        PH_HEAD  = 3'd0,
        PH_MPRE  = 3'd1,
        PH_BYTE  = 3'd2,
        PH_MPOST = 3'd3,
        PH_TAIL  = 3'd4,
        PH_DONE  = 3'd5
    } t_phase;

    localparam logic [7:0] HEAD_TXT [13] = '{
        8'h7B, 8'h20, 8'h22, 8'h54, 8'h4F, 8'h50, 8'h49,
        8'h43, 8'h22, 8'h20, 8'h3A, 8'h20, 8'h22
    };
    localparam logic [7:0] MID_TXT [15] = '{
        8'h22, 8'h2C, 8'h20, 8'h22, 8'h43, 8'h4F, 8'h4E, 8'h54,
        8'h45, 8'h4E, 8'h54, 8'h22, 8'h20, 8'h3A, 8'h20
    };

    t_phase     r_phase;
    logic [3:0] r_idx;
    logic       r_started;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       r_eom;

    logic [4:0] w_present;
    t_phase     w_phase;
    t_phase     w_next;
    logic [3:0] w_idx;
    logic [3:0] w_last_idx;
    logic       w_phase_last;
    logic       w_item_last;
    logic       w_fire;
    logic [7:0] w_byte;

    // Next phase present in the command after phase p.
    function automatic t_phase fn_after(input logic [4:0] pres, input t_phase p);
        t_phase r;
        r = PH_DONE;
        priority if (p < PH_MPRE && pres[1]) begin
            r = PH_MPRE;
        end else if (p < PH_BYTE && pres[2]) begin
            r = PH_BYTE;
        end else if (p < PH_MPOST && pres[3]) begin
            r = PH_MPOST;
        end else if (p < PH_TAIL && pres[4]) begin
            r = PH_TAIL;
        end else begin
            r = PH_DONE;
        end
        return r;
    endfunction

    function automatic logic [7:0] fn_hex(input logic [3:0] n);
        return (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h57 + {4'd0, n});
    endfunction

    assign w_present = {i_q_cmd.tail, i_q_cmd.mpost, (i_q_cmd.kind != K_NONE),
                        i_q_cmd.mpre, i_q_cmd.head};

    // A fresh command starts at its first present phase without a bubble.
    assign w_phase = r_started ? r_phase
                   : (w_present[0] ? PH_HEAD : fn_after(w_present, PH_HEAD));
    assign w_idx   = r_started ? r_idx : 4'd0;
    assign w_next  = fn_after(w_present, w_phase);

    always_comb begin
        unique case (w_phase)
            PH_HEAD:           w_last_idx = 4'd12;
            PH_MPRE, PH_MPOST: w_last_idx = 4'd14;
            PH_TAIL:           w_last_idx = 4'd1;
            PH_BYTE: begin
                unique case (i_q_cmd.kind)
                    K_ESC2:  w_last_idx = 4'd1;
                    K_ESC6:  w_last_idx = 4'd5;
                    default: w_last_idx = 4'd0;
                endcase
            end
            default:           w_last_idx = 4'd0;
        endcase
    end

    always_comb begin
        unique case (w_phase)
            PH_HEAD:           w_byte = HEAD_TXT[w_idx];
            PH_MPRE, PH_MPOST: w_byte = MID_TXT[w_idx];
            PH_TAIL:           w_byte = w_idx[0] ? 8'h7D : 8'h20;
            PH_BYTE: begin
                unique case (i_q_cmd.kind)
                    K_ESC2: w_byte = (w_idx == 4'd0) ? 8'h5C : i_q_cmd.data;
                    K_ESC6: begin
                        unique case (w_idx)
                            4'd0:    w_byte = 8'h5C;
                            4'd1:    w_byte = 8'h75;
                            4'd2:    w_byte = 8'h30;
                            4'd3:    w_byte = 8'h30;
                            4'd4:    w_byte = fn_hex(i_q_cmd.data[7:4]);
                            default: w_byte = fn_hex(i_q_cmd.data[3:0]);
                        endcase
                    end
                    default: w_byte = i_q_cmd.data;
                endcase
            end
            default:           w_byte = i_q_cmd.data;
        endcase
    end

    assign w_phase_last = (w_idx == w_last_idx);
    assign w_item_last  = w_phase_last & (w_next == PH_DONE);
    assign w_fire       = i_q_valid & (~r_valid | i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEAD;
            r_idx     <= 4'd0;
            r_started <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            if (w_fire) begin
                r_valid <= 1'b1;
                r_byte  <= w_byte;
                r_last  <= w_item_last;
                r_eom   <= (w_phase == PH_TAIL) & w_idx[0];
                if (w_item_last) begin
                    r_started <= 1'b0;
                end else if (w_phase_last) begin
                    r_phase   <= w_next;
                    r_idx     <= 4'd0;
                    r_started <= 1'b1;
                end else begin
                    r_phase   <= w_phase;
                    r_idx     <= w_idx + 4'd1;
                    r_started <= 1'b1;
                end
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_pop            = w_fire & w_item_last;
    assign o_valid          = r_valid;
    assign o_out_byte       = r_byte;
    assign o_last_of_run    = r_last;
    assign o_end_of_message = r_eom;

endmodule
